// ===== hdl/jls_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jls_pkg: shared definitions for the jump label stack
// Operation and status codes, result layout and parameter defaults.
// ----------------------------------------------------------------------------
package jls_pkg;

    localparam int STACK_DEPTH_DEF       = 32;
    localparam int PATCHES_PER_ENTRY_DEF = 64;

    localparam int LABEL_W   = 32;
    localparam int ADDR_W    = 32;
    localparam int SLOT_W    = 5;
    localparam int COUNT_W   = 7;
    localparam int STATUS_W  = 3;

    typedef enum logic [2:0] {
        KIND_PUSH      = 3'd0,
        KIND_POP       = 3'd1,
        KIND_TOP       = 3'd2,
        KIND_FIND_BRK  = 3'd3,
        KIND_FIND_CONT = 3'd4,
        KIND_ADD_PATCH = 3'd5,
        KIND_SET_CONT  = 3'd6,
        KIND_CLEAR     = 3'd7
    } kind_t;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_PFULL    = 3'd4;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [LABEL_W-1:0]  label;
        logic                sw_flag;
        logic [ADDR_W-1:0]   cont;
        logic [COUNT_W-1:0]  count;
        logic                pvalid;
        logic [ADDR_W-1:0]   pout;
        logic                last;
    } result_t;

endpackage

// ===== hdl/jump_label_stack_with_patches_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jump_label_stack_with_patches_core: loop and switch target stack
// A bounded stack of jump targets, each with a label, a switch flag, a
// continue offset and a list of forward break patch addresses.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake        Signals
//  -------   --------------   ---------------------------------------------
//  command   start && !busy   kind, label_id, switch_flag, entry_index,
//                             patch_address, target_offset
//  result    strobe           status, slot, found_label, found_is_switch,
//                             continue_offset, patch_count, patch_valid,
//                             patch_out, last
//
// A command transfer is followed by a dispatch state. Push, clear and
// every command that fails its depth or index check finish there. Top,
// add patch and set continue read the entry memory once and then finish;
// add patch can still fail there on a full patch list. A find walks the
// stack through the single entry memory read port, one entry per cycle,
// from the top down, until an entry matches or the bottom entry is passed.
// A pop reads its entry and then streams its patch addresses through the
// patch memory read port, one result per cycle.
// Each result sits on the result ports for exactly one cycle with strobe
// high; the receiver cannot stall, so nothing ever waits on the output.
// A new command is taken in the same cycle the final result is shown.
// Reset clears the depth and the sequencer only. The memories need no
// clearing pass: only entries below the depth and patches below an
// entry's count are ever read, and those are always written first.
// ----------------------------------------------------------------------------
module jump_label_stack_with_patches_core #(
    parameter int STACK_DEPTH       = jls_pkg::STACK_DEPTH_DEF,
    parameter int PATCHES_PER_ENTRY = jls_pkg::PATCHES_PER_ENTRY_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [2:0]                      kind,
    input  logic [jls_pkg::LABEL_W-1:0]     label_id,
    input  logic                            switch_flag,
    input  logic [jls_pkg::SLOT_W-1:0]      entry_index,
    input  logic [jls_pkg::ADDR_W-1:0]      patch_address,
    input  logic [jls_pkg::ADDR_W-1:0]      target_offset,
    output logic                            strobe,
    output logic [jls_pkg::STATUS_W-1:0]    status,
    output logic [jls_pkg::SLOT_W-1:0]      slot,
    output logic [jls_pkg::LABEL_W-1:0]     found_label,
    output logic                            found_is_switch,
    output logic [jls_pkg::ADDR_W-1:0]      continue_offset,
    output logic [jls_pkg::COUNT_W-1:0]     patch_count,
    output logic                            patch_valid,
    output logic [jls_pkg::ADDR_W-1:0]      patch_out,
    output logic                            last
);

    // Widths derived from the stack geometry.
    localparam int DW   = $clog2(STACK_DEPTH + 1);
    localparam int SW   = $clog2(STACK_DEPTH);
    localparam int CW   = $clog2(PATCHES_PER_ENTRY + 1);
    localparam int PIW  = (PATCHES_PER_ENTRY > 1) ? $clog2(PATCHES_PER_ENTRY) : 1;
    localparam int PAW  = $clog2(STACK_DEPTH * PATCHES_PER_ENTRY);
    localparam int CMPW = (DW > jls_pkg::SLOT_W) ? DW : jls_pkg::SLOT_W;

    typedef struct packed {
        logic [jls_pkg::LABEL_W-1:0] label;
        logic                        sw_flag;
        logic [jls_pkg::ADDR_W-1:0]  cont;
        logic [CW-1:0]               count;
    } entry_t;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DISPATCH = 7'b0000010,
        S_TOP      = 7'b0000100,
        S_SEARCH   = 7'b0001000,
        S_MODIFY   = 7'b0010000,
        S_POP      = 7'b0100000,
        S_EMIT     = 7'b1000000
    } state_t;

    // Control state.
    state_t         state_reg, state_next;
    logic [DW-1:0]  depth_reg, depth_next;
    logic           strobe_reg, strobe_next;

    // Latched command and walk pointers.
    jls_pkg::kind_t              kind_reg;
    logic [jls_pkg::LABEL_W-1:0] label_reg;
    logic                        sw_reg;
    logic [jls_pkg::SLOT_W-1:0]  idx_reg;
    logic [jls_pkg::ADDR_W-1:0]  paddr_reg;
    logic [jls_pkg::ADDR_W-1:0]  toff_reg;
    logic [SW-1:0]               cur_reg, cur_next;
    logic [PIW-1:0]              pi_reg, pi_next;
    jls_pkg::result_t            res_reg, res_next;

    // Memories and their registered read data.
    entry_t                      ent_mem [STACK_DEPTH];
    logic [jls_pkg::ADDR_W-1:0]  patch_mem [STACK_DEPTH * PATCHES_PER_ENTRY];
    entry_t                      ent_rd_reg;
    logic [jls_pkg::ADDR_W-1:0]  patch_rd_reg;

    logic                        ent_we, ent_re;
    logic [SW-1:0]               ent_waddr, ent_raddr;
    entry_t                      ent_wdata;
    logic                        patch_we, patch_re;
    logic [PAW-1:0]              patch_waddr, patch_raddr;

    logic                        accept;
    logic                        match;
    logic [CW-1:0]               pi_plus;
    logic [PIW-1:0]              pi_inc;
    logic [DW-1:0]               depth_dec;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign pi_plus   = CW'(pi_reg) + CW'(1);
    assign pi_inc    = pi_reg + PIW'(1);
    assign depth_dec = depth_reg - DW'(1);

    // A continue skips switch entries; a zero label matches any entry label.
    assign match = !((kind_reg == jls_pkg::KIND_FIND_CONT) && ent_rd_reg.sw_flag)
                   && ((label_reg == '0) || (ent_rd_reg.label == label_reg));

    function automatic jls_pkg::result_t fail_res(logic [jls_pkg::STATUS_W-1:0] st);
        jls_pkg::result_t r;
        r        = '0;
        r.status = st;
        r.last   = 1'b1;
        return r;
    endfunction

    function automatic jls_pkg::result_t entry_res(logic [SW-1:0] s, entry_t e,
                                                   logic pv,
                                                   logic [jls_pkg::ADDR_W-1:0] po,
                                                   logic lst);
        jls_pkg::result_t r;
        r.status    = jls_pkg::ST_OK;
        r.slot      = jls_pkg::SLOT_W'(s);
        r.label     = e.label;
        r.sw_flag   = e.sw_flag;
        r.cont      = e.cont;
        r.count     = jls_pkg::COUNT_W'(e.count);
        r.pvalid    = pv;
        r.pout      = po;
        r.last      = lst;
        return r;
    endfunction

    function automatic logic [PAW-1:0] patch_loc(logic [SW-1:0] s, logic [PIW-1:0] i);
        return PAW'(PAW'(s) * PAW'(PATCHES_PER_ENTRY) + PAW'(i));
    endfunction

    always_comb
    begin
        state_next  = state_reg;
        depth_next  = depth_reg;
        strobe_next = 1'b0;
        cur_next    = cur_reg;
        pi_next     = pi_reg;
        res_next    = res_reg;
        ent_we      = 1'b0;
        ent_waddr   = cur_reg;
        ent_wdata   = ent_rd_reg;
        ent_re      = 1'b0;
        ent_raddr   = cur_reg;
        patch_we    = 1'b0;
        patch_waddr = patch_loc(cur_reg, PIW'(ent_rd_reg.count));
        patch_re    = 1'b0;
        patch_raddr = patch_loc(cur_reg, pi_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                case (kind_reg)
                    jls_pkg::KIND_PUSH:
                    begin
                        if (depth_reg == DW'(STACK_DEPTH))
                        begin
                            res_next = fail_res(jls_pkg::ST_FULL);
                        end
                        else
                        begin
                            ent_we            = 1'b1;
                            ent_waddr         = SW'(depth_reg);
                            ent_wdata.label   = label_reg;
                            ent_wdata.sw_flag = sw_reg;
                            ent_wdata.cont    = '0;
                            ent_wdata.count   = '0;
                            depth_next        = depth_reg + DW'(1);
                            res_next = entry_res(SW'(depth_reg), ent_wdata, 1'b0, '0, 1'b1);
                        end
                        strobe_next = 1'b1;
                        state_next  = S_IDLE;
                    end

                    jls_pkg::KIND_POP,
                    jls_pkg::KIND_TOP:
                    begin
                        if (depth_reg == '0)
                        begin
                            res_next    = fail_res(jls_pkg::ST_EMPTY);
                            strobe_next = 1'b1;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            ent_re    = 1'b1;
                            ent_raddr = SW'(depth_dec);
                            cur_next  = SW'(depth_dec);
                            if (kind_reg == jls_pkg::KIND_POP)
                            begin
                                depth_next = depth_dec;
                                state_next = S_POP;
                            end
                            else
                            begin
                                state_next = S_TOP;
                            end
                        end
                    end

                    jls_pkg::KIND_FIND_BRK,
                    jls_pkg::KIND_FIND_CONT:
                    begin
                        if (depth_reg == '0)
                        begin
                            res_next    = fail_res(jls_pkg::ST_NOTFOUND);
                            strobe_next = 1'b1;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            ent_re     = 1'b1;
                            ent_raddr  = SW'(depth_dec);
                            cur_next   = SW'(depth_dec);
                            state_next = S_SEARCH;
                        end
                    end

                    jls_pkg::KIND_ADD_PATCH,
                    jls_pkg::KIND_SET_CONT:
                    begin
                        if (CMPW'(idx_reg) >= CMPW'(depth_reg))
                        begin
                            res_next    = fail_res(jls_pkg::ST_NOTFOUND);
                            strobe_next = 1'b1;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            ent_re     = 1'b1;
                            ent_raddr  = SW'(idx_reg);
                            cur_next   = SW'(idx_reg);
                            state_next = S_MODIFY;
                        end
                    end

                    default:
                    begin
                        // Clear: the stack becomes empty, result carries no entry.
                        depth_next  = '0;
                        res_next    = fail_res(jls_pkg::ST_OK);
                        strobe_next = 1'b1;
                        state_next  = S_IDLE;
                    end
                endcase
            end

            S_TOP:
            begin
                res_next    = entry_res(cur_reg, ent_rd_reg, 1'b0, '0, 1'b1);
                strobe_next = 1'b1;
                state_next  = S_IDLE;
            end

            S_SEARCH:
            begin
                if (match)
                begin
                    res_next    = entry_res(cur_reg, ent_rd_reg, 1'b0, '0, 1'b1);
                    strobe_next = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (cur_reg == '0)
                begin
                    res_next    = fail_res(jls_pkg::ST_NOTFOUND);
                    strobe_next = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    ent_re    = 1'b1;
                    ent_raddr = cur_reg - SW'(1);
                    cur_next  = cur_reg - SW'(1);
                end
            end

            S_MODIFY:
            begin
                ent_waddr = cur_reg;
                if (kind_reg == jls_pkg::KIND_SET_CONT)
                begin
                    ent_we         = 1'b1;
                    ent_wdata.cont = toff_reg;
                    res_next = entry_res(cur_reg, ent_wdata, 1'b0, '0, 1'b1);
                end
                else if (ent_rd_reg.count >= CW'(PATCHES_PER_ENTRY))
                begin
                    res_next = fail_res(jls_pkg::ST_PFULL);
                end
                else
                begin
                    patch_we        = 1'b1;
                    ent_we          = 1'b1;
                    ent_wdata.count = ent_rd_reg.count + CW'(1);
                    res_next = entry_res(cur_reg, ent_wdata, 1'b0, '0, 1'b1);
                end
                strobe_next = 1'b1;
                state_next  = S_IDLE;
            end

            S_POP:
            begin
                if (ent_rd_reg.count == '0)
                begin
                    res_next    = entry_res(cur_reg, ent_rd_reg, 1'b0, '0, 1'b1);
                    strobe_next = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    patch_re    = 1'b1;
                    patch_raddr = patch_loc(cur_reg, '0);
                    pi_next     = '0;
                    state_next  = S_EMIT;
                end
            end

            S_EMIT:
            begin
                strobe_next = 1'b1;
                if (pi_plus == ent_rd_reg.count)
                begin
                    res_next   = entry_res(cur_reg, ent_rd_reg, 1'b1, patch_rd_reg, 1'b1);
                    state_next = S_IDLE;
                end
                else
                begin
                    res_next    = entry_res(cur_reg, ent_rd_reg, 1'b1, patch_rd_reg, 1'b0);
                    patch_re    = 1'b1;
                    patch_raddr = patch_loc(cur_reg, pi_inc);
                    pi_next     = pi_inc;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            depth_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            depth_reg  <= depth_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= jls_pkg::kind_t'(kind);
            label_reg <= label_id;
            sw_reg    <= switch_flag;
            idx_reg   <= entry_index;
            paddr_reg <= patch_address;
            toff_reg  <= target_offset;
        end
        cur_reg <= cur_next;
        pi_reg  <= pi_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        if (ent_re)
        begin
            ent_rd_reg <= ent_mem[ent_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (patch_we)
        begin
            patch_mem[patch_waddr] <= paddr_reg;
        end
        if (patch_re)
        begin
            patch_rd_reg <= patch_mem[patch_raddr];
        end
    end

    assign strobe          = strobe_reg;
    assign status          = res_reg.status;
    assign slot            = res_reg.slot;
    assign found_label     = res_reg.label;
    assign found_is_switch = res_reg.sw_flag;
    assign continue_offset = res_reg.cont;
    assign patch_count     = res_reg.count;
    assign patch_valid     = res_reg.pvalid;
    assign patch_out       = res_reg.pout;
    assign last            = res_reg.last;

endmodule
